@@ rtl/fpga_passive_serial_config_core_macros.svh @@
// Assertion macros shared by the passive-serial configuration core.
// Depends on nothing; included by the top level only.
`ifndef FPGA_PASSIVE_SERIAL_CONFIG_CORE_MACROS_SVH
`define FPGA_PASSIVE_SERIAL_CONFIG_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fpsc_pkg.sv @@
// Package for the passive-serial configuration core: widths, codes, reset values.
// Used by the interfaces, the register block and the top level.
package fpsc_pkg;

  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned BYTE_CNT_W     = 24;
  localparam int unsigned TIME_W         = 16;
  localparam int unsigned CFG_DATA_W     = 24;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CHECK_US  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_US     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT    = 3'd4;

  localparam logic [BYTE_CNT_W-1:0] MAX_BYTES_RST     = 24'd16777215;
  localparam logic [TIME_W-1:0]     LOW_CHECK_US_RST  = 16'd1;
  localparam logic [TIME_W-1:0]     SETTLE_US_RST     = 16'd40;
  localparam logic [TIME_W-1:0]     POLL_INTERVAL_RST = 16'd100;
  localparam logic [TIME_W-1:0]     POLL_LIMIT_RST    = 16'd500;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;

  localparam logic [2:0] ST_BUSY          = 3'd0;
  localparam logic [2:0] ST_STATUS_HIGH   = 3'd1;
  localparam logic [2:0] ST_DONE_AT_CHECK = 3'd2;
  localparam logic [2:0] ST_DONE_RELEASE  = 3'd3;
  localparam logic [2:0] ST_POLL_TIMEOUT  = 3'd4;
  localparam logic [2:0] ST_STATUS_LOW    = 3'd5;
  localparam logic [2:0] ST_COUNT_OVER    = 3'd6;
  localparam logic [2:0] ST_DONE          = 3'd7;

  typedef struct packed {
    logic [BYTE_CNT_W-1:0] max_bytes;
    logic [TIME_W-1:0]     low_check_us;
    logic [TIME_W-1:0]     settle_us;
    logic [TIME_W-1:0]     poll_interval_us;
    logic [TIME_W-1:0]     poll_limit;
  } cfg_t;

endpackage

@@ rtl/fpsc_if.sv @@
// Stream interfaces for the input items and result items of the core.
// Depends on fpsc_pkg.
interface fpsc_in_if;
  import fpsc_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       nstatus_in;
  logic       confdone_in;

  modport source (output valid, mode, data_byte, nstatus_in, confdone_in, input ready);
  modport sink (input valid, mode, data_byte, nstatus_in, confdone_in, output ready);
endinterface

interface fpsc_out_if;
  import fpsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  nconfig_out;
  logic                  send_valid;
  logic [7:0]            send_byte;
  logic [2:0]            status;
  logic [BYTE_CNT_W-1:0] byte_count;
  logic                  finished;

  modport source (output valid, nconfig_out, send_valid, send_byte, status, byte_count,
                  finished, input ready);
  modport sink (input valid, nconfig_out, send_valid, send_byte, status, byte_count,
                finished, output ready);
endinterface

@@ rtl/fpsc_cfg_regs.sv @@
// Configuration register block of the passive-serial configuration core.
// Depends on fpsc_pkg for register indexes, widths and reset values.
module fpsc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fpsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fpsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output fpsc_pkg::cfg_t                     cfg
);
  import fpsc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_bytes        <= MAX_BYTES_RST;
      cfg.low_check_us     <= LOW_CHECK_US_RST;
      cfg.settle_us        <= SETTLE_US_RST;
      cfg.poll_interval_us <= POLL_INTERVAL_RST;
      cfg.poll_limit       <= POLL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_BYTES:     cfg.max_bytes        <= cfg_data[BYTE_CNT_W-1:0];
        REG_LOW_CHECK_US:  cfg.low_check_us     <= cfg_data[TIME_W-1:0];
        REG_SETTLE_US:     cfg.settle_us        <= cfg_data[TIME_W-1:0];
        REG_POLL_INTERVAL: cfg.poll_interval_us <= cfg_data[TIME_W-1:0];
        REG_POLL_LIMIT:    cfg.poll_limit       <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/fpga_passive_serial_config_core.sv @@
// Top level of the passive-serial configuration core: sequencer and result register.
// Depends on fpsc_pkg, fpsc_if, fpsc_cfg_regs and the assertion macro header.
//
// The host drives the in_ch channel with one item per transfer: a tick for each
// microsecond, a start item to begin configuration, or a data byte of the image
// together with the sampled status and done pins. Every accepted item yields
// exactly one result on out_ch: the level for the request pin, an optional byte
// for the external serializer, a status code, the byte count and a finished flag.
// The sequencer and counters update in the cycle of the transfer, and the result
// appears in the output register in the cycle after it. The core takes one item per
// clock; the single output register sets that figure, since a new item is taken in
// the same cycle that the previous result is taken. When the receiver stalls, the
// result holds and in_ch.ready drops until it is taken. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them only
// while the core is idle; the core does not enforce it. Reset returns the sequencer
// to idle, releases the request, clears the counters and loads register defaults.
`include "fpga_passive_serial_config_core_macros.svh"

module fpga_passive_serial_config_core #(
  parameter int unsigned COUNT_BITS = fpsc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpsc_pkg::CFG_DATA_W-1:0] cfg_data,
  fpsc_in_if.sink                         in_ch,
  fpsc_out_if.source                      out_ch
);
  import fpsc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > BYTE_CNT_W) ? COUNT_BITS : BYTE_CNT_W;
  localparam logic [TIME_W-1:0] TIME_SAT = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LOW_WAIT, PH_HOLD, PH_REL_WAIT, PH_POLL, PH_STREAM, PH_FINISHED
  } phase_t;

  cfg_t cfg;

  fpsc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phase_t                phase, phase_next;
  logic [TIME_W-1:0]     wait_counter, wait_counter_next;
  logic [TIME_W-1:0]     poll_counter, poll_counter_next;
  logic [COUNT_BITS-1:0] sent_count, sent_count_next;
  logic [2:0]            result_code, result_code_next;
  logic                  request_level, request_level_next;
  logic                  send_valid_next;
  logic [7:0]            send_byte_next;

  logic                  in_fire;
  logic [TIME_W-1:0]     wait_inc;
  logic [TIME_W-1:0]     poll_inc;
  logic [TIME_W-1:0]     wait_len;
  logic                  wait_over;
  logic [COUNT_BITS-1:0] sent_inc;
  logic [CMP_W-1:0]      sent_ext;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign wait_inc = (wait_counter != TIME_SAT) ? wait_counter + 1'b1 : wait_counter;
  assign poll_inc = (poll_counter != TIME_SAT) ? poll_counter + 1'b1 : poll_counter;
  assign sent_inc = (sent_count != COUNT_SAT) ? sent_count + 1'b1 : sent_count;
  assign sent_ext = CMP_W'(sent_inc);

  always_comb begin
    unique case (phase)
      PH_LOW_WAIT: wait_len = cfg.low_check_us;
      PH_POLL:     wait_len = cfg.poll_interval_us;
      default:     wait_len = cfg.settle_us;
    endcase
  end

  assign wait_over = wait_inc >= wait_len;

  always_comb begin
    phase_next         = phase;
    wait_counter_next  = wait_counter;
    poll_counter_next  = poll_counter;
    sent_count_next    = sent_count;
    result_code_next   = result_code;
    request_level_next = request_level;
    send_valid_next    = 1'b0;
    send_byte_next     = 8'd0;
    unique case (in_ch.mode)
      MODE_START: begin
        request_level_next = 1'b0;
        phase_next         = PH_LOW_WAIT;
        wait_counter_next  = '0;
        poll_counter_next  = '0;
        sent_count_next    = '0;
        result_code_next   = ST_BUSY;
      end
      MODE_DATA: begin
        if (phase == PH_STREAM) begin
          priority if (in_ch.confdone_in) begin
            result_code_next = ST_DONE;
            phase_next       = PH_FINISHED;
          end else if (!in_ch.nstatus_in) begin
            result_code_next = ST_STATUS_LOW;
            phase_next       = PH_FINISHED;
          end else begin
            send_valid_next = 1'b1;
            send_byte_next  = in_ch.data_byte;
            sent_count_next = sent_inc;
            if (sent_ext > CMP_W'(cfg.max_bytes)) begin
              result_code_next = ST_COUNT_OVER;
              phase_next       = PH_FINISHED;
            end
          end
        end
      end
      MODE_TICK: begin
        if (phase == PH_LOW_WAIT || phase == PH_HOLD || phase == PH_REL_WAIT ||
            phase == PH_POLL) begin
          wait_counter_next = wait_over ? '0 : wait_inc;
        end
        if (wait_over) begin
          unique case (phase)
            PH_LOW_WAIT: begin
              priority if (in_ch.nstatus_in) begin
                result_code_next = ST_STATUS_HIGH;
                phase_next       = PH_FINISHED;
              end else if (in_ch.confdone_in) begin
                result_code_next = ST_DONE_AT_CHECK;
                phase_next       = PH_FINISHED;
              end else begin
                phase_next = PH_HOLD;
              end
            end
            PH_HOLD: begin
              request_level_next = 1'b1;
              phase_next         = PH_REL_WAIT;
            end
            PH_REL_WAIT: begin
              poll_counter_next = '0;
              priority if (in_ch.confdone_in) begin
                result_code_next = ST_DONE_RELEASE;
                phase_next       = PH_FINISHED;
              end else if (in_ch.nstatus_in) begin
                phase_next = PH_STREAM;
              end else begin
                phase_next = PH_POLL;
              end
            end
            PH_POLL: begin
              poll_counter_next = poll_inc;
              if (poll_inc >= cfg.poll_limit) begin
                result_code_next = ST_POLL_TIMEOUT;
                phase_next       = PH_FINISHED;
              end else if (in_ch.nstatus_in) begin
                phase_next = PH_STREAM;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wait_counter  <= '0;
      poll_counter  <= '0;
      sent_count    <= '0;
      result_code   <= ST_BUSY;
      request_level <= 1'b1;
      out_ch.valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase         <= phase_next;
        wait_counter  <= wait_counter_next;
        poll_counter  <= poll_counter_next;
        sent_count    <= sent_count_next;
        result_code   <= result_code_next;
        request_level <= request_level_next;
      end
      out_ch.valid <= in_fire || (out_ch.valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ch.nconfig_out <= request_level_next;
      out_ch.send_valid  <= send_valid_next;
      out_ch.send_byte   <= send_byte_next;
      out_ch.status      <= result_code_next;
      out_ch.byte_count  <= BYTE_CNT_W'(CMP_W'(sent_count_next));
      out_ch.finished    <= (phase_next == PH_FINISHED);
    end
  end

  `FPSC_ASSERT_SAME(a_send_status, clk, rst, out_ch.valid && out_ch.send_valid,
    out_ch.status == ST_BUSY || out_ch.status == ST_COUNT_OVER,
    "byte sent with a status that forbids sending")
  `FPSC_ASSERT_SAME(a_finished_code, clk, rst, out_ch.valid,
    out_ch.finished == (out_ch.status != ST_BUSY),
    "finished flag disagrees with status code")
  `FPSC_ASSERT_NEXT(a_start_result, clk, rst, in_fire && in_ch.mode == MODE_START,
    out_ch.valid && !out_ch.nconfig_out && out_ch.status == ST_BUSY && !out_ch.finished,
    "start transfer did not pull the request pin low")

endmodule
